/* rtl/ship_drrip_cache_replacement_macros.svh */
// Assertion macros for the SHiP/DRRIP replacement block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SHIP_DRRIP_CACHE_REPLACEMENT_MACROS_SVH
`define SHIP_DRRIP_CACHE_REPLACEMENT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdcr_pkg.sv */
// Shared types and constants of the SHiP/DRRIP replacement block.
// No dependencies; imported by the controller, datapath and top level.
package sdcr_pkg;

  // Fixed field widths of the beats
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int PC_W     = 64;
  localparam int ADDR_W   = 48;
  localparam int VICTIM_W = 4;

  // Default geometry
  localparam int NUM_SETS_DEF       = 2048;
  localparam int NUM_WAYS_DEF       = 16;
  localparam int SIG_WIDTH_DEF      = 6;
  localparam int SELECTOR_WIDTH_DEF = 10;
  localparam int LEADER_SETS_DEF    = 64;

  // Re-reference values
  localparam int          RRPV_W    = 2;
  localparam logic [1:0]  RRPV_MAX  = 2'd3;
  localparam logic [1:0]  RRPV_LONG = 2'd2;
  localparam logic [1:0]  RRPV_NEAR = 2'd0;

  // Reuse counters
  localparam logic [1:0]  REUSE_MAX  = 2'd3;
  localparam logic [1:0]  REUSE_PRED = 2'd2;
  localparam logic [1:0]  REUSE_ZERO = 2'd0;

  // Signature taken from address bits above the line offset
  localparam int SIG_SHIFT = 6;

  // Random source for bimodal insertion
  localparam int           LFSR_W    = 16;
  localparam logic [15:0]  LFSR_SEED = 16'hACE1;
  localparam int           DRAW_BITS = 5;

  // Beat kinds
  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Controller states
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_FILL  = 5'b01000,
    ST_HOLD  = 5'b10000
  } sdcr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // sweep step of the reset clearing pass
    logic capture;   // beat accepted: latch fields, read set rows
    logic look;      // set rows available: victim / hit work
    logic fill;      // fill insertion and counter decrement
    logic out_load;  // load the output register
    logic res_live;  // output comes from this cycle's victim search
  } sdcr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_fill;   // captured beat is a fill on a valid way
  } sdcr_sts_t;

endpackage

/* rtl/sdcr_ctrl.sv */
// Sequencer of the SHiP/DRRIP replacement block: clearing pass, per-beat steps
// and the output handshake. Depends on sdcr_pkg.
module sdcr_ctrl #(
  parameter int NUM_SETS  = sdcr_pkg::NUM_SETS_DEF,
  parameter int SIG_WIDTH = sdcr_pkg::SIG_WIDTH_DEF,
  localparam int CLR_LEN  = (NUM_SETS > (1 << SIG_WIDTH)) ? NUM_SETS : (1 << SIG_WIDTH),
  localparam int CLR_W    = $clog2(CLR_LEN)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sdcr_pkg::sdcr_sts_t sts_i,
  output sdcr_pkg::sdcr_cmd_t cmd_o,
  output logic [CLR_W-1:0]    clr_addr_o
);
  import sdcr_pkg::*;

  sdcr_state_e      state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign clr_addr_o  = clr_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        clr_d       = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look     = 1'b1;
        cmd_o.res_live = 1'b1;
        if (sts_i.is_fill) begin
          state_d = ST_FILL;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Output valid: set on load, dropped when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/sdcr_dpath.sv */
// Datapath of the SHiP/DRRIP replacement block: set rows, signature rows,
// reuse table, set-dueling selector, LFSR and output register. Uses sdcr_pkg.
module sdcr_dpath #(
  parameter int NUM_SETS       = sdcr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS       = sdcr_pkg::NUM_WAYS_DEF,
  parameter int SIG_WIDTH      = sdcr_pkg::SIG_WIDTH_DEF,
  parameter int SELECTOR_WIDTH = sdcr_pkg::SELECTOR_WIDTH_DEF,
  parameter int LEADER_SETS    = sdcr_pkg::LEADER_SETS_DEF,
  localparam int CLR_LEN = (NUM_SETS > (1 << SIG_WIDTH)) ? NUM_SETS : (1 << SIG_WIDTH),
  localparam int CLR_W   = $clog2(CLR_LEN)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdcr_pkg::sdcr_cmd_t            cmd_i,
  output sdcr_pkg::sdcr_sts_t            sts_o,
  input  logic [CLR_W-1:0]               clr_addr_i,
  input  logic                           kind_i,
  input  logic [sdcr_pkg::SET_IN_W-1:0]  set_index_i,
  input  logic [sdcr_pkg::WAY_IN_W-1:0]  way_index_i,
  input  logic                           is_hit_i,
  input  logic [sdcr_pkg::PC_W-1:0]      pc_i,
  input  logic [sdcr_pkg::ADDR_W-1:0]    phys_addr_i,
  output logic [sdcr_pkg::VICTIM_W-1:0]  victim_way_o,
  output logic                           done_kind_o
);
  import sdcr_pkg::*;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_COUNT = 1 << SIG_WIDTH;
  localparam int MAX_QUO   = ((1 << SET_IN_W) - 1) / NUM_SETS;
  // Leader layout: one SRRIP leader at the start of each stride, one BRRIP
  // leader half a stride later.
  localparam int STRIDE    = (NUM_SETS / LEADER_SETS == 0) ? 1 : NUM_SETS / LEADER_SETS;
  localparam int HALF      = STRIDE / 2;
  localparam int ST_LOG    = (STRIDE > 1) ? $clog2(STRIDE) : 0;
  // Exact quotient by reciprocal for set numbers below 2^SET_W
  localparam int          RCP_K  = SET_W + ST_LOG;
  localparam logic [63:0] RCP_M  = ((64'd1 << RCP_K) + 64'(STRIDE) - 64'd1) / 64'(STRIDE);
  localparam int          PROD_W = 2 * SET_W + 1;

  typedef logic [NUM_WAYS-1:0][RRPV_W-1:0]    rrpv_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_WIDTH-1:0] sig_row_t;

  // Storage
  rrpv_row_t  rrpv_mem  [NUM_SETS];
  sig_row_t   sig_mem   [NUM_SETS];
  logic [1:0] reuse_mem [SIG_COUNT];

  // Captured beat
  logic                 kind_q, hit_q;
  logic [WAY_IN_W-1:0]  way_q;
  logic [SET_W-1:0]     set_q;
  logic [SIG_WIDTH-1:0] sig_q;

  // Read data and step results
  rrpv_row_t            rrpv_rd_q;
  sig_row_t             sig_rd_q;
  logic [1:0]           reuse_a_q, reuse_b_q;
  logic [SET_W-1:0]     quo_q, quo_d;
  logic [VICTIM_W-1:0]  res_victim_q;
  logic [VICTIM_W-1:0]  out_victim_q;
  logic                 out_kind_q;

  // Policy state
  logic [SELECTOR_WIDTH-1:0] sel_q, sel_d;
  logic [LFSR_W-1:0]         lfsr_q, lfsr_d, lfsr_step;

  logic [SET_W-1:0]     set_red;
  logic [SIG_WIDTH-1:0] sig_in, old_sig;
  logic [WAY_W-1:0]     way_ix;
  logic                 way_ok, hit_upd;
  logic [PROD_W-1:0]    prod;

  // Set index reduced modulo NUM_SETS: compares against constant multiples
  function automatic logic [SET_W-1:0] set_reduce(input logic [SET_IN_W-1:0] x);
    int base;
    base = 0;
    for (int k = 1; k <= MAX_QUO; k++) begin
      if (int'(x) >= k * NUM_SETS) begin
        base = k * NUM_SETS;
      end
    end
    return SET_W'(int'(x) - base);
  endfunction

  assign set_red = set_reduce(set_index_i);
  assign sig_in  = pc_i[SIG_WIDTH-1:0] ^ phys_addr_i[SIG_SHIFT +: SIG_WIDTH];
  assign way_ix  = WAY_W'(way_q);
  assign way_ok  = (int'(way_q) < NUM_WAYS);
  assign hit_upd = (kind_q == KIND_UPDATE) && hit_q && way_ok;
  assign old_sig = sig_rd_q[way_ix];
  assign sts_o.is_fill = (kind_q == KIND_UPDATE) && !hit_q && way_ok;

  // Victim search with aging
  logic [NUM_WAYS-1:0] at3, at2, at1;
  logic [1:0]          rrpv_top, age_delta;
  rrpv_row_t           aged_row;
  logic [VICTIM_W-1:0] victim, victim_live;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      at3[w] = (rrpv_rd_q[w] == 2'd3);
      at2[w] = (rrpv_rd_q[w] == 2'd2);
      at1[w] = (rrpv_rd_q[w] == 2'd1);
    end
  end

  always_comb begin
    if (|at3) begin
      rrpv_top = 2'd3;
    end else if (|at2) begin
      rrpv_top = 2'd2;
    end else if (|at1) begin
      rrpv_top = 2'd1;
    end else begin
      rrpv_top = 2'd0;
    end
    age_delta = RRPV_MAX - rrpv_top;
    victim    = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged_row[w] = rrpv_rd_q[w] + age_delta;
      if (rrpv_rd_q[w] == rrpv_top) begin
        victim = VICTIM_W'(w);
      end
    end
  end

  assign victim_live = (kind_q == KIND_VICTIM) ? victim : '0;

  // Leader classification from the registered quotient
  int   lead_rem;
  logic quo_in, lead_srrip, lead_brrip, srrip_mode, draw_hit;
  logic [1:0] fill_rrpv;

  assign prod  = PROD_W'(set_q) * PROD_W'(RCP_M[SET_W:0]);
  assign quo_d = SET_W'(prod >> RCP_K);

  always_comb begin
    lead_rem   = int'(set_q) - int'(quo_q) * STRIDE;
    quo_in     = int'(quo_q) < LEADER_SETS;
    lead_srrip = quo_in && (lead_rem == 0);
    lead_brrip = quo_in && !lead_srrip && (lead_rem == HALF);
    srrip_mode = lead_srrip || (!lead_brrip && sel_q[SELECTOR_WIDTH-1]);
  end

  // Insertion value; only the bimodal path steps the LFSR
  assign lfsr_step = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LFSR_W-1:1]};
  assign draw_hit  = (lfsr_step[DRAW_BITS-1:0] == '0);

  always_comb begin
    lfsr_d = lfsr_q;
    if (reuse_a_q >= REUSE_PRED) begin
      fill_rrpv = RRPV_NEAR;
    end else if (srrip_mode) begin
      fill_rrpv = RRPV_LONG;
    end else begin
      fill_rrpv = draw_hit ? RRPV_LONG : RRPV_MAX;
      if (cmd_i.fill) begin
        lfsr_d = lfsr_step;
      end
    end
  end

  // Selector: SRRIP leader miss lowers, BRRIP leader miss raises
  always_comb begin
    sel_d = sel_q;
    if (cmd_i.fill) begin
      if (lead_srrip && (sel_q != '0)) begin
        sel_d = sel_q - 1'b1;
      end else if (lead_brrip && (sel_q != '1)) begin
        sel_d = sel_q + 1'b1;
      end
    end
  end

  // Write ports
  logic       clr_row, clr_reuse;
  logic       rrpv_we, sig_we, reuse_we;
  logic [SET_W-1:0]     row_wa;
  logic [SIG_WIDTH-1:0] reuse_wa;
  rrpv_row_t  rrpv_wd;
  sig_row_t   sig_wd;
  logic [1:0] reuse_wd;

  assign clr_row   = cmd_i.clear && (int'(clr_addr_i) < NUM_SETS);
  assign clr_reuse = cmd_i.clear && (int'(clr_addr_i) < SIG_COUNT);

  always_comb begin
    rrpv_we  = clr_row || (cmd_i.look && (kind_q == KIND_VICTIM)) ||
               (cmd_i.look && hit_upd) || cmd_i.fill;
    sig_we   = clr_row || (cmd_i.look && hit_upd) || cmd_i.fill;
    reuse_we = clr_reuse || (cmd_i.look && hit_upd) || cmd_i.fill;
    row_wa   = cmd_i.clear ? clr_addr_i[SET_W-1:0] : set_q;
    rrpv_wd  = rrpv_rd_q;
    sig_wd   = sig_rd_q;
    reuse_wa = sig_q;
    reuse_wd = reuse_a_q;
    if (cmd_i.clear) begin
      rrpv_wd  = '1;
      sig_wd   = '0;
      reuse_wa = clr_addr_i[SIG_WIDTH-1:0];
      reuse_wd = REUSE_ZERO;
    end else if (cmd_i.look && (kind_q == KIND_VICTIM)) begin
      rrpv_wd = aged_row;
    end else if (cmd_i.look) begin
      // hit: promote the way and train its signature
      rrpv_wd[way_ix] = RRPV_NEAR;
      sig_wd[way_ix]  = sig_q;
      reuse_wd        = (reuse_a_q == REUSE_MAX) ? REUSE_MAX : reuse_a_q + 2'd1;
    end else begin
      // fill: insert, then untrain the evicted signature
      rrpv_wd[way_ix] = fill_rrpv;
      sig_wd[way_ix]  = sig_q;
      reuse_wa        = old_sig;
      reuse_wd        = (reuse_b_q == REUSE_ZERO) ? REUSE_ZERO : reuse_b_q - 2'd1;
    end
  end

  // Set row memories
  always_ff @(posedge clk_i) begin
    if (rrpv_we) begin
      rrpv_mem[row_wa] <= rrpv_wd;
    end
    if (cmd_i.capture) begin
      rrpv_rd_q <= rrpv_mem[set_red];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sig_we) begin
      sig_mem[row_wa] <= sig_wd;
    end
    if (cmd_i.capture) begin
      sig_rd_q <= sig_mem[set_red];
    end
  end

  // Reuse table: port A reads the new signature, port B the evicted one
  always_ff @(posedge clk_i) begin
    if (reuse_we) begin
      reuse_mem[reuse_wa] <= reuse_wd;
    end
    if (cmd_i.capture) begin
      reuse_a_q <= reuse_mem[sig_in];
    end
    if (cmd_i.look) begin
      reuse_b_q <= reuse_mem[old_sig];
    end
  end

  // Beat capture, step results and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      hit_q  <= is_hit_i;
      way_q  <= way_index_i;
      set_q  <= set_red;
      sig_q  <= sig_in;
    end
    if (cmd_i.look) begin
      quo_q        <= quo_d;
      res_victim_q <= victim_live;
    end
    if (cmd_i.out_load) begin
      out_victim_q <= cmd_i.res_live ? victim_live : res_victim_q;
      out_kind_q   <= kind_q;
    end
  end

  // Policy state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= SELECTOR_WIDTH'(1) << (SELECTOR_WIDTH - 1);
      lfsr_q <= LFSR_SEED;
    end else begin
      sel_q  <= sel_d;
      lfsr_q <= lfsr_d;
    end
  end

  assign victim_way_o = out_victim_q;
  assign done_kind_o  = out_kind_q;

endmodule

/* rtl/ship_drrip_cache_replacement.sv */
// SHiP-lite / DRRIP set-dueling replacement policy, top level.
// Depends on sdcr_pkg, sdcr_ctrl, sdcr_dpath and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per request:
//   a victim request (kind 0) or an access update (kind 1, hit or fill).
//   Output channel (out_valid_o / out_ready_i) returns exactly one beat per
//   request: the victim way (zero for updates) and the echoed kind.
//   One request is in work at a time. Victim requests and hits load the
//   output register from the lookup step; fills add a fill step, since the
//   evicted signature's reuse counter is read in a second reuse-table access.
//   The next request is taken in the cycle the result appears; a new request
//   is not taken before the last one is through, a limit set by the single-port
//   read-modify-write of the set rows and reuse table.
//   After reset the block sweeps its memories, one row per cycle, over
//   max(NUM_SETS, 2^SIG_WIDTH) rows (2048 by default) with in_ready_o low.
//   A stalled output holds its beat; a finished request waits in the block
//   until the output register frees, and no new request is taken meanwhile.
`include "ship_drrip_cache_replacement_macros.svh"

module ship_drrip_cache_replacement #(
  parameter int NUM_SETS       = sdcr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS       = sdcr_pkg::NUM_WAYS_DEF,
  parameter int SIG_WIDTH      = sdcr_pkg::SIG_WIDTH_DEF,
  parameter int SELECTOR_WIDTH = sdcr_pkg::SELECTOR_WIDTH_DEF,
  parameter int LEADER_SETS    = sdcr_pkg::LEADER_SETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [sdcr_pkg::SET_IN_W-1:0]  set_index_i,
  input  logic [sdcr_pkg::WAY_IN_W-1:0]  way_index_i,
  input  logic                           is_hit_i,
  input  logic [sdcr_pkg::PC_W-1:0]      pc_i,
  input  logic [sdcr_pkg::ADDR_W-1:0]    phys_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sdcr_pkg::VICTIM_W-1:0]  victim_way_o,
  output logic                           done_kind_o
);
  import sdcr_pkg::*;

  localparam int CLR_LEN = (NUM_SETS > (1 << SIG_WIDTH)) ? NUM_SETS : (1 << SIG_WIDTH);
  localparam int CLR_W   = $clog2(CLR_LEN);

  sdcr_cmd_t        cmd;
  sdcr_sts_t        sts;
  logic [CLR_W-1:0] clr_addr;

  sdcr_ctrl #(
    .NUM_SETS  (NUM_SETS),
    .SIG_WIDTH (SIG_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .clr_addr_o  (clr_addr)
  );

  sdcr_dpath #(
    .NUM_SETS       (NUM_SETS),
    .NUM_WAYS       (NUM_WAYS),
    .SIG_WIDTH      (SIG_WIDTH),
    .SELECTOR_WIDTH (SELECTOR_WIDTH),
    .LEADER_SETS    (LEADER_SETS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .clr_addr_i   (clr_addr),
    .kind_i       (kind_i),
    .set_index_i  (set_index_i),
    .way_index_i  (way_index_i),
    .is_hit_i     (is_hit_i),
    .pc_i         (pc_i),
    .phys_addr_i  (phys_addr_i),
    .victim_way_o (victim_way_o),
    .done_kind_o  (done_kind_o)
  );

  // Checks
  `SDCR_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second beat accepted while busy")
  `SDCR_ASSERT_NEXT(a_look_follows_accept, in_valid_i && in_ready_o, cmd.look, "no lookup after accept")
  `SDCR_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_o || out_ready_i, "pending result overwritten")
  `SDCR_ASSERT_NOW(a_fill_after_look, cmd.fill, $past(cmd.look), "fill step without lookup")

endmodule
